// ===== src/sctp_pkg.sv =====
// shared types and constants for the serial command target parser
// no dependencies

package sctp_pkg;

  // message codes
  localparam logic [3:0] MSG_IGNORED     = 4'd0;
  localparam logic [3:0] MSG_STOPPED     = 4'd1;
  localparam logic [3:0] MSG_STARTED     = 4'd2;
  localparam logic [3:0] MSG_SEL_RED     = 4'd3;
  localparam logic [3:0] MSG_SEL_GREEN   = 4'd4;
  localparam logic [3:0] MSG_SEL_BLUE    = 4'd5;
  localparam logic [3:0] MSG_ECHO        = 4'd6;
  localparam logic [3:0] MSG_COMMIT_RED   = 4'd7;
  localparam logic [3:0] MSG_COMMIT_GREEN = 4'd8;
  localparam logic [3:0] MSG_COMMIT_BLUE  = 4'd9;
  localparam logic [3:0] MSG_COMMIT_NONE  = 4'd10;

  // colour selection codes
  localparam logic [1:0] COLOUR_NONE  = 2'd0;
  localparam logic [1:0] COLOUR_RED   = 2'd1;
  localparam logic [1:0] COLOUR_GREEN = 2'd2;
  localparam logic [1:0] COLOUR_BLUE  = 2'd3;

  // character codes
  localparam logic [7:0] CHAR_F      = 8'h46;
  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam int OUT_VALUE_W = 7;

  typedef struct packed {
    logic [3:0]             message;
    logic [7:0]             echo_char;
    logic [OUT_VALUE_W-1:0] reported_value;
  } sctp_result_t;

endpackage

// ===== src/serial_command_target_parser.sv =====
// serial command target parser: top level with input register, state and result register
// depends on sctp_pkg and sctp_decode
// path: input register, then result register, from input beat to result beat
// throughput: one character per cycle, sustained while the output side takes each result
// one decode pass per character between the input register and the result register
// reset: synchronous, clears run flag, selection, pending value, targets and both valids

module serial_command_target_parser import sctp_pkg::*; #(
  parameter int MAX_VALUE = 99
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_char
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] message, [11:4] echo_char, [18:12] reported_value, [19] running,
  // [26:20] red goal, [33:27] green goal, [40:34] blue goal, [47:41] zero
  output logic [47:0] m_tdata
);

  localparam int VW = $clog2(MAX_VALUE + 1);

  logic          in_valid;
  logic [7:0]    in_char;
  logic          fire;

  logic          run_flag;
  logic [1:0]    colour;
  logic [VW-1:0] pending;
  logic [VW-1:0] red;
  logic [VW-1:0] green;
  logic [VW-1:0] blue;

  logic          run_flag_next;
  logic [1:0]    colour_next;
  logic [VW-1:0] pending_next;
  logic [VW-1:0] red_next;
  logic [VW-1:0] green_next;
  logic [VW-1:0] blue_next;
  sctp_result_t  res;

  logic          out_valid;
  sctp_result_t  out_res;
  logic          out_running;
  logic [VW-1:0] out_red;
  logic [VW-1:0] out_green;
  logic [VW-1:0] out_blue;

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  sctp_decode #(
    .MAX_VALUE(MAX_VALUE)
  ) u_decode (
    .rx_char       (in_char),
    .run_flag      (run_flag),
    .colour        (colour),
    .pending       (pending),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .run_flag_next (run_flag_next),
    .colour_next   (colour_next),
    .pending_next  (pending_next),
    .red_next      (red_next),
    .green_next    (green_next),
    .blue_next     (blue_next),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag <= 1'b0;
      colour   <= COLOUR_NONE;
      pending  <= '0;
      red      <= '0;
      green    <= '0;
      blue     <= '0;
    end else if (fire) begin
      run_flag <= run_flag_next;
      colour   <= colour_next;
      pending  <= pending_next;
      red      <= red_next;
      green    <= green_next;
      blue     <= blue_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res     <= res;
      out_running <= run_flag_next;
      out_red     <= red_next;
      out_green   <= green_next;
      out_blue    <= blue_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0,
                     OUT_VALUE_W'(out_blue),
                     OUT_VALUE_W'(out_green),
                     OUT_VALUE_W'(out_red),
                     out_running,
                     out_res.reported_value,
                     out_res.echo_char,
                     out_res.message};

  // pending value never exceeds the saturation limit
  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    pending <= VW'(MAX_VALUE))
    else $error("pending value above limit");

  // a stop beat always leaves the machine stopped with no selection
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.message == MSG_STOPPED |=> !run_flag && colour == COLOUR_NONE && pending == '0)
    else $error("stop did not clear state");

  // a start beat sets the run flag
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    fire && res.message == MSG_STARTED |=> run_flag)
    else $error("start did not set run flag");

  // while running only a stop can change state
  a_running_frozen: assert property (@(posedge clk) disable iff (rst)
    fire && run_flag && res.message != MSG_STOPPED |=>
      run_flag && $stable(pending) && $stable(red) && $stable(green) && $stable(blue))
    else $error("state changed while running");

  // echo field is only set with the echo message
  a_echo_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.message != MSG_ECHO |-> out_res.echo_char == '0)
    else $error("echo char without echo message");

endmodule

// ===== src/sctp_decode.sv =====
// command decode and next-state logic for one received character
// depends on sctp_pkg

module sctp_decode import sctp_pkg::*; #(
  parameter int MAX_VALUE = 99
) (
  input  logic [7:0]                           rx_char,
  input  logic                                 run_flag,
  input  logic [1:0]                           colour,
  input  logic [$clog2(MAX_VALUE+1)-1:0]       pending,
  input  logic [$clog2(MAX_VALUE+1)-1:0]       red,
  input  logic [$clog2(MAX_VALUE+1)-1:0]       green,
  input  logic [$clog2(MAX_VALUE+1)-1:0]       blue,
  output logic                                 run_flag_next,
  output logic [1:0]                           colour_next,
  output logic [$clog2(MAX_VALUE+1)-1:0]       pending_next,
  output logic [$clog2(MAX_VALUE+1)-1:0]       red_next,
  output logic [$clog2(MAX_VALUE+1)-1:0]       green_next,
  output logic [$clog2(MAX_VALUE+1)-1:0]       blue_next,
  output sctp_result_t                         res
);

  localparam int VW = $clog2(MAX_VALUE + 1);
  localparam int WW = VW + 4;

  logic [7:0]    upper;
  logic          is_digit;
  logic [WW-1:0] fold;
  logic [VW-1:0] fold_sat;

  always_comb begin
    if (rx_char >= CHAR_LOW_A && rx_char <= CHAR_LOW_Z) begin
      upper = rx_char - CASE_OFFSET;
    end else begin
      upper = rx_char;
    end
  end

  assign is_digit = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);

  // pending * 10 + digit
  assign fold = WW'({pending, 3'b000}) + WW'({pending, 1'b0}) + WW'(rx_char[3:0]);
  assign fold_sat = (fold > WW'(MAX_VALUE)) ? VW'(MAX_VALUE) : fold[VW-1:0];

  always_comb begin
    run_flag_next      = run_flag;
    colour_next        = colour;
    pending_next       = pending;
    red_next           = red;
    green_next         = green;
    blue_next          = blue;
    res.message        = MSG_IGNORED;
    res.echo_char      = '0;
    res.reported_value = '0;
    priority if (upper == CHAR_F) begin
      run_flag_next = 1'b0;
      colour_next   = COLOUR_NONE;
      pending_next  = '0;
      res.message   = MSG_STOPPED;
    end else if (run_flag) begin
      res.message = MSG_IGNORED;
    end else if (upper == CHAR_S) begin
      run_flag_next = 1'b1;
      res.message   = MSG_STARTED;
    end else if (upper == CHAR_R) begin
      colour_next  = COLOUR_RED;
      pending_next = '0;
      res.message  = MSG_SEL_RED;
    end else if (upper == CHAR_G) begin
      colour_next  = COLOUR_GREEN;
      pending_next = '0;
      res.message  = MSG_SEL_GREEN;
    end else if (upper == CHAR_B) begin
      colour_next  = COLOUR_BLUE;
      pending_next = '0;
      res.message  = MSG_SEL_BLUE;
    end else if (is_digit) begin
      pending_next  = fold_sat;
      res.echo_char = rx_char;
      res.message   = MSG_ECHO;
    end else if (rx_char == CHAR_CR || rx_char == CHAR_LF) begin
      res.reported_value = OUT_VALUE_W'(pending);
      pending_next       = '0;
      unique case (colour)
        COLOUR_RED: begin
          red_next    = pending;
          res.message = MSG_COMMIT_RED;
        end
        COLOUR_GREEN: begin
          green_next  = pending;
          res.message = MSG_COMMIT_GREEN;
        end
        COLOUR_BLUE: begin
          blue_next   = pending;
          res.message = MSG_COMMIT_BLUE;
        end
        default: begin
          res.message = MSG_COMMIT_NONE;
        end
      endcase
    end else begin
      res.message = MSG_IGNORED;
    end
  end

endmodule
